FILE: rtl/rle15_pkg.sv
// ----------------------------------------------------------------------------
// rle15_pkg
// Shared types, constants and helper functions for the RGB565 run encoder.
// ----------------------------------------------------------------------------
package rle15_pkg;

   localparam int unsigned WORD_W  = 16;
   localparam int unsigned COUNT_W = 12;
   localparam int unsigned SLOTS   = 4;
   localparam int unsigned SLOT_CNT_W = $clog2(SLOTS + 1);

   localparam logic [COUNT_W-1:0] RUN_LIMIT  = 12'd4095;
   localparam logic [WORD_W-1:0]  REPEAT_BIT = 16'h0020;
   localparam logic [WORD_W-1:0]  COUNT_TAG  = 16'h3000;

   // words of one run flush
   typedef struct packed {
      logic [1:0]        cnt;
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
   } flush_type;

   // all words caused by one pixel, in transfer order from slot 0
   typedef struct packed {
      logic [SLOT_CNT_W-1:0]        cnt;
      logic                         last;
      logic [SLOTS-1:0][WORD_W-1:0] words;
   } burst_type;

   function automatic logic [WORD_W-1:0] pack_colour(logic [7:0] b0, logic [7:0] b1,
                                                     logic [7:0] b2);
      return {b2[7:3], b1[7:2], b0[7:3]};
   endfunction

   function automatic flush_type flush_run(logic [WORD_W-1:0] colour,
                                           logic [COUNT_W-1:0] n);
      flush_type f;
      f.cnt = 2'd0;
      f.w0  = colour & ~REPEAT_BIT;
      f.w1  = colour & ~REPEAT_BIT;
      if (n == 12'd1) begin
         f.cnt = 2'd1;
      end else if (n == 12'd2) begin
         f.cnt = 2'd2;
      end else if (n != 12'd0) begin
         f.cnt = 2'd2;
         f.w0  = colour | REPEAT_BIT;
         f.w1  = COUNT_TAG | {4'h0, n - 12'd1};
      end
      return f;
   endfunction

endpackage

FILE: rtl/rle15_front.sv
// ----------------------------------------------------------------------------
// rle15_front
// Pixel input register, run state and the encoder that turns one pixel into
// a burst of up to four words.
// ----------------------------------------------------------------------------
module rle15_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_first_byte,
   input  logic [7:0]           req_second_byte,
   input  logic [7:0]           req_third_byte,
   input  logic                 req_end_of_image,
   input  logic                 buf_free,
   output logic                 load,
   output rle15_pkg::burst_type burst
);

   logic                                   in_valid_ff, in_valid_in;
   logic [rle15_pkg::WORD_W-1:0]           colour_ff;
   logic                                   eoi_ff;
   logic [rle15_pkg::WORD_W-1:0]           run_colour_ff, run_colour_in;
   logic [rle15_pkg::COUNT_W-1:0]          run_length_ff, run_length_in;
   logic [rle15_pkg::COUNT_W-1:0]          len_inc;
   logic [rle15_pkg::WORD_W-1:0]           mid_colour;
   logic [rle15_pkg::COUNT_W-1:0]          mid_length;
   rle15_pkg::flush_type                   fa, fb;
   logic                                   take;

   assign load      = in_valid_ff & buf_free;
   assign req_ready = ~in_valid_ff | buf_free;
   assign take      = req_valid & req_ready;
   assign len_inc   = run_length_ff + 12'd1;

   always_comb begin
      fa = '0;
      if (colour_ff == run_colour_ff) begin
         mid_colour = run_colour_ff;
         if (len_inc == rle15_pkg::RUN_LIMIT) begin
            fa         = rle15_pkg::flush_run(run_colour_ff, len_inc);
            mid_length = '0;
         end else begin
            mid_length = len_inc;
         end
      end else begin
         fa         = rle15_pkg::flush_run(run_colour_ff, run_length_ff);
         mid_colour = colour_ff;
         mid_length = 12'd1;
      end

      fb = '0;
      if (eoi_ff) begin
         fb            = rle15_pkg::flush_run(mid_colour, mid_length);
         run_colour_in = '0;
         run_length_in = '0;
      end else begin
         run_colour_in = mid_colour;
         run_length_in = mid_length;
      end
   end

   always_comb begin
      burst.cnt  = rle15_pkg::SLOT_CNT_W'(fa.cnt) + rle15_pkg::SLOT_CNT_W'(fb.cnt);
      burst.last = eoi_ff;
      case (fa.cnt)
         2'd0: burst.words = {fb.w0, fb.w0, fb.w1, fb.w0};
         2'd1: burst.words = {fb.w0, fb.w1, fb.w0, fa.w0};
         default: burst.words = {fb.w1, fb.w0, fa.w1, fa.w0};
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         run_colour_ff <= '0;
         run_length_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (load) begin
            run_colour_ff <= run_colour_in;
            run_length_ff <= run_length_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         colour_ff <= rle15_pkg::pack_colour(req_first_byte, req_second_byte,
                                             req_third_byte);
         eoi_ff    <= req_end_of_image;
      end
   end

endmodule

FILE: rtl/rle15_outbuf.sv
// ----------------------------------------------------------------------------
// rle15_outbuf
// Result buffer: holds one burst and drains it one word per transfer.
// ----------------------------------------------------------------------------
module rle15_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  rle15_pkg::burst_type burst,
   output logic                 buf_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_code_word,
   output logic                 rsp_final_word
);

   logic [rle15_pkg::SLOTS-1:0][rle15_pkg::WORD_W-1:0] word_ff;
   logic [rle15_pkg::SLOT_CNT_W-1:0]                   cnt_ff, cnt_in;
   logic                                               last_ff;
   logic                                               pop;

   assign rsp_valid      = (cnt_ff != '0);
   assign pop            = rsp_valid & rsp_ready;
   assign buf_free       = (cnt_ff == '0) |
                           ((cnt_ff == rle15_pkg::SLOT_CNT_W'(1)) & rsp_ready);
   assign rsp_code_word  = word_ff[0];
   assign rsp_final_word = last_ff & (cnt_ff == rle15_pkg::SLOT_CNT_W'(1));

   always_comb begin
      cnt_in = cnt_ff;
      if (load) begin
         cnt_in = burst.cnt;
      end else if (pop) begin
         cnt_in = cnt_ff - rle15_pkg::SLOT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= burst.words;
         last_ff <= burst.last;
      end else if (pop) begin
         for (int i = 0; i < rle15_pkg::SLOTS - 1; i++) begin
            word_ff[i] <= word_ff[i+1];
         end
      end
   end

endmodule

FILE: rtl/rgb15_run_length_encoder_core.sv
// ----------------------------------------------------------------------------
// rgb15_run_length_encoder_core
// Run-length encoder for a pixel stream, packing each pixel to RGB565.
//
// Input channel req_*: one pixel per transfer, three bytes plus an end flag.
// Result channel rsp_*: one 16-bit code word per transfer; rsp_final_word
// marks the last word of an image.
// A pixel is encoded while it sits in the input register and its words
// (zero to four) are loaded into the result buffer once the buffer is free;
// the result buffer register then shows the first word.
// Throughput is one pixel per cycle while each pixel yields at most one word
// and the receiver takes every word; a pixel that yields more words holds the
// result buffer until they are taken, and the next pixel waits in the input
// register until the single-word result port has drained the buffer.
// Reset clears the run to colour zero, length zero, and empties both stages.
// When the receiver stalls, the buffered word holds and the input register
// fills, after which req_ready drops.
// ----------------------------------------------------------------------------
module rgb15_run_length_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_first_byte,
   input  logic [7:0]  req_second_byte,
   input  logic [7:0]  req_third_byte,
   input  logic        req_end_of_image,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_word,
   output logic        rsp_final_word
);

   logic                 buf_free;
   logic                 load;
   rle15_pkg::burst_type burst;

   rle15_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_first_byte   (req_first_byte),
      .req_second_byte  (req_second_byte),
      .req_third_byte   (req_third_byte),
      .req_end_of_image (req_end_of_image),
      .buf_free         (buf_free),
      .load             (load),
      .burst            (burst)
   );

   rle15_outbuf u_outbuf (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .burst          (burst),
      .buf_free       (buf_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_word  (rsp_code_word),
      .rsp_final_word (rsp_final_word)
   );

endmodule
